[hdl/arpr_pkg.sv]
// ----------------------------------------------------------------------------
// ARP responder package
// Shared types and constants of the ARP request responder.
// ----------------------------------------------------------------------------
package arpr_pkg;

    localparam int unsigned ARP_LEN = 42;
    localparam int unsigned REPLY_W = ARP_LEN * 8;

    localparam logic [5:0] POS_MAX      = 6'd63;
    localparam logic [5:0] POS_LAST     = 6'(ARP_LEN - 1);
    localparam logic [5:0] POS_ETYPE_HI = 6'd12;
    localparam logic [5:0] POS_ETYPE_LO = 6'd13;
    localparam logic [5:0] POS_OPER_HI  = 6'd20;
    localparam logic [5:0] POS_OPER_LO  = 6'd21;
    localparam logic [5:0] POS_SHA      = 6'd22;
    localparam logic [5:0] POS_SPA      = 6'd28;
    localparam logic [5:0] POS_THA      = 6'd32;
    localparam logic [5:0] POS_TPA      = 6'd38;

    localparam logic [15:0] ETYPE_ARP   = 16'h0806;
    localparam logic [15:0] HTYPE_ETH   = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  HLEN_ETH    = 8'd6;
    localparam logic [7:0]  PLEN_IPV4   = 8'd4;
    localparam logic [15:0] OPER_REQ    = 16'h0001;
    localparam logic [15:0] OPER_REPLY  = 16'h0002;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] REG_STATION_MAC = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STATION_IP  = 1'd1;

    typedef struct packed {
        logic [47:0] rq_mac;
        logic [31:0] rq_ip;
        logic [47:0] st_mac;
        logic [31:0] st_ip;
    } t_reply_src;

    typedef struct packed {
        logic hit;
        logic near_end;
    } t_rx_stat;

endpackage

[hdl/arpr_in_if.sv]
// ----------------------------------------------------------------------------
// Frame input channel
// Valid/ready channel carrying one received frame byte per item.
// ----------------------------------------------------------------------------
interface arpr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       end_of_frame;

    modport source (output valid, output frame_byte, output end_of_frame, input ready);
    modport sink   (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

[hdl/arpr_out_if.sv]
// ----------------------------------------------------------------------------
// Reply output channel
// Valid/ready channel carrying one ARP reply byte per item.
// ----------------------------------------------------------------------------
interface arpr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] reply_byte;
    logic       reply_last;

    modport source (output valid, output reply_byte, output reply_last, input ready);
    modport sink   (input valid, input reply_byte, input reply_last, output ready);
endinterface

[hdl/arpr_rx.sv]
// ----------------------------------------------------------------------------
// ARP request parser
// Tracks byte position, header checks, sender addresses and target match.
// ----------------------------------------------------------------------------
module arpr_rx (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic [7:0]            i_byte,
    input  logic                  i_eof,
    input  logic [31:0]           i_station_ip,
    input  logic [47:0]           i_station_mac,
    output arpr_pkg::t_rx_stat    o_stat,
    output arpr_pkg::t_reply_src  o_src
);

    logic [5:0]  r_pos,    n_pos;
    logic        r_hdr_ok, n_hdr_ok;
    logic        r_tgt_ok, n_tgt_ok;
    logic [47:0] r_rq_mac, n_rq_mac;
    logic [31:0] r_rq_ip,  n_rq_ip;
    logic [5:0]  w_tpa_k;
    logic [7:0]  w_ip_byte;
    logic        w_hit;

    assign w_tpa_k = r_pos - arpr_pkg::POS_TPA;

    always_comb begin
        case (w_tpa_k[1:0])
            2'd0:    w_ip_byte = i_station_ip[31:24];
            2'd1:    w_ip_byte = i_station_ip[23:16];
            2'd2:    w_ip_byte = i_station_ip[15:8];
            default: w_ip_byte = i_station_ip[7:0];
        endcase
    end

    always_comb begin
        n_pos    = r_pos;
        n_hdr_ok = r_hdr_ok;
        n_tgt_ok = r_tgt_ok;
        n_rq_mac = r_rq_mac;
        n_rq_ip  = r_rq_ip;
        w_hit    = 1'b0;
        if (i_fire) begin
            if (r_pos <= arpr_pkg::POS_LAST) begin
                if (r_pos == arpr_pkg::POS_ETYPE_HI && i_byte != arpr_pkg::ETYPE_ARP[15:8])
                    n_hdr_ok = 1'b0;
                if (r_pos == arpr_pkg::POS_ETYPE_LO && i_byte != arpr_pkg::ETYPE_ARP[7:0])
                    n_hdr_ok = 1'b0;
                if (r_pos == arpr_pkg::POS_OPER_HI && i_byte != arpr_pkg::OPER_REQ[15:8])
                    n_hdr_ok = 1'b0;
                if (r_pos == arpr_pkg::POS_OPER_LO && i_byte != arpr_pkg::OPER_REQ[7:0])
                    n_hdr_ok = 1'b0;
                if (r_pos >= arpr_pkg::POS_SHA && r_pos < arpr_pkg::POS_SPA)
                    n_rq_mac = {r_rq_mac[39:0], i_byte};
                if (r_pos >= arpr_pkg::POS_SPA && r_pos < arpr_pkg::POS_THA)
                    n_rq_ip = {r_rq_ip[23:0], i_byte};
                if (r_pos >= arpr_pkg::POS_TPA && i_byte != w_ip_byte)
                    n_tgt_ok = 1'b0;
            end
            if (r_pos != arpr_pkg::POS_MAX)
                n_pos = r_pos + 6'd1;
            if (i_eof) begin
                w_hit    = (r_pos >= arpr_pkg::POS_LAST) && n_hdr_ok && n_tgt_ok;
                n_pos    = '0;
                n_hdr_ok = 1'b1;
                n_tgt_ok = 1'b1;
                n_rq_mac = '0;
                n_rq_ip  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_hdr_ok <= 1'b1;
            r_tgt_ok <= 1'b1;
            r_rq_mac <= '0;
            r_rq_ip  <= '0;
        end else begin
            r_pos    <= n_pos;
            r_hdr_ok <= n_hdr_ok;
            r_tgt_ok <= n_tgt_ok;
            r_rq_mac <= n_rq_mac;
            r_rq_ip  <= n_rq_ip;
        end
    end

    assign o_stat.hit      = w_hit;
    assign o_stat.near_end = (r_pos >= arpr_pkg::POS_LAST);
    assign o_src.rq_mac    = r_rq_mac;
    assign o_src.rq_ip     = r_rq_ip;
    assign o_src.st_mac    = i_station_mac;
    assign o_src.st_ip     = i_station_ip;

    hit_needs_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hit |-> (i_fire && i_eof && r_pos >= arpr_pkg::POS_LAST))
        else $error("reply raised on a short or unflagged frame");

    eof_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_eof) |=> (r_pos == '0 && r_hdr_ok && r_tgt_ok))
        else $error("frame state not cleared after end of frame");

endmodule

[hdl/arpr_tx.sv]
// ----------------------------------------------------------------------------
// ARP reply generator
// Loads a full reply frame into a shift register and sends it byte by byte.
// ----------------------------------------------------------------------------
module arpr_tx (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  arpr_pkg::t_reply_src i_src,
    output logic                 o_busy,
    arpr_out_if.source           o_reply
);

    logic [arpr_pkg::REPLY_W-1:0] r_shift, n_shift;
    logic [5:0]                   r_idx,   n_idx;
    logic                         r_busy,  n_busy;
    logic                         w_fire;
    logic                         w_last;

    assign w_fire = r_busy && o_reply.ready;
    assign w_last = (r_idx == arpr_pkg::POS_LAST);

    always_comb begin
        n_shift = r_shift;
        n_idx   = r_idx;
        n_busy  = r_busy;
        if (w_fire) begin
            n_shift = {r_shift[arpr_pkg::REPLY_W-9:0], 8'h00};
            n_idx   = r_idx + 6'd1;
            if (w_last)
                n_busy = 1'b0;
        end
        if (i_load) begin
            n_shift = {i_src.rq_mac, i_src.st_mac, arpr_pkg::ETYPE_ARP,
                       arpr_pkg::HTYPE_ETH, arpr_pkg::PTYPE_IPV4,
                       arpr_pkg::HLEN_ETH, arpr_pkg::PLEN_IPV4, arpr_pkg::OPER_REPLY,
                       i_src.st_mac, i_src.st_ip, i_src.rq_mac, i_src.rq_ip};
            n_idx   = '0;
            n_busy  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
        r_shift <= n_shift;
    end

    // free for a new load once the final byte is leaving
    assign o_busy             = r_busy && !(w_fire && w_last);
    assign o_reply.valid      = r_busy;
    assign o_reply.reply_byte = r_shift[arpr_pkg::REPLY_W-1 -: 8];
    assign o_reply.reply_last = w_last;

    load_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_busy || (w_fire && w_last)))
        else $error("reply loaded over one still in flight");

    last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_last && !i_load) |=> !r_busy)
        else $error("burst continues past final byte");

    load_starts_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> (r_busy && r_idx == '0))
        else $error("reply load did not start a burst");

endmodule

[hdl/arp_request_responder_core.sv]
// ----------------------------------------------------------------------------
// ARP request responder core
// Answers ARP requests for the station IPv4 address with a 42-byte reply.
//
//   channel   dir  payload                      handshake
//   i_frame   in   frame_byte[7:0], end_of_frame valid/ready
//   o_reply   out  reply_byte[7:0], reply_last   valid/ready
//   i_cfg_*   in   index[0], data[47:0]          write enable, no wait
//
// One frame byte per cycle while the input is not stalled; parsing is a single registered pass.
// A matching request loads a 42-byte reply that leaves at one item per cycle while o_reply is ready,
// the first one valid in the cycle after its end-of-frame byte is taken.
// Input stalls only when a frame's 42nd or later byte arrives while an earlier
// reply still has items beyond the one accepted in that cycle.
// Reset is synchronous, active low; no clearing pass.
// ----------------------------------------------------------------------------
module arp_request_responder_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    arpr_in_if.sink                             i_frame,
    arpr_out_if.source                          o_reply,
    input  logic                                i_cfg_wr_en,
    input  logic [arpr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [arpr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [47:0]          r_station_mac;
    logic [31:0]          r_station_ip;
    logic                 w_fire;
    logic                 w_tx_busy;
    arpr_pkg::t_rx_stat   w_stat;
    arpr_pkg::t_reply_src w_src;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_mac <= '0;
            r_station_ip  <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                arpr_pkg::REG_STATION_MAC: r_station_mac <= i_cfg_data[47:0];
                arpr_pkg::REG_STATION_IP:  r_station_ip  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign i_frame.ready = !(w_tx_busy && w_stat.near_end);
    assign w_fire        = i_frame.valid && i_frame.ready;

    arpr_rx u_rx (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_byte        (i_frame.frame_byte),
        .i_eof         (i_frame.end_of_frame),
        .i_station_ip  (r_station_ip),
        .i_station_mac (r_station_mac),
        .o_stat        (w_stat),
        .o_src         (w_src)
    );

    arpr_tx u_tx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_stat.hit),
        .i_src   (w_src),
        .o_busy  (w_tx_busy),
        .o_reply (o_reply)
    );

endmodule
